// ===== rtl/core/pppc_pkg.sv =====
// ----------------------------------------------------------------------------
// pppc_pkg
// Shared widths, constants and helper functions for the polar pursuit
// proportional controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pppc_pkg;

  // field widths
  localparam int DW = 16;
  localparam int XFRAC = 14;
  localparam int CW = 34;
  localparam int ATAN_ENTRIES = 24;

  typedef logic signed [CW-1:0] cord_t;

  // constants of the vectoring transform
  localparam logic [29:0] GAIN_K_Q30 = 30'd652032874;
  localparam cord_t HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [DW-1:0] BEARING_LIMIT = 16'sd25736;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET_DIST  = 2'd0;
  localparam logic [1:0] REG_LINEAR_GAIN  = 2'd1;
  localparam logic [1:0] REG_ANGULAR_GAIN = 2'd2;

  // configuration reset values
  localparam logic [14:0] TARGET_DIST_RST  = 15'd256;
  localparam logic [11:0] LINEAR_GAIN_RST  = 12'd384;
  localparam logic [11:0] ANGULAR_GAIN_RST = 12'd1024;

  // atan(2^-i) in Q30 radians, rounded to nearest
  function automatic cord_t atan_q30(input logic [4:0] idx);
    cord_t a;
    case (idx)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      5'd12: a = 34'sd262144;
      5'd13: a = 34'sd131072;
      5'd14: a = 34'sd65536;
      5'd15: a = 34'sd32768;
      5'd16: a = 34'sd16384;
      5'd17: a = 34'sd8192;
      5'd18: a = 34'sd4096;
      5'd19: a = 34'sd2048;
      5'd20: a = 34'sd1024;
      5'd21: a = 34'sd512;
      5'd22: a = 34'sd256;
      5'd23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  // saturate a signed value to 16 bits
  function automatic logic signed [DW-1:0] sat16(input logic signed [31:0] v);
    logic signed [DW-1:0] s;
    if (v > 32'sd32767) begin
      s = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      s = 16'sh8000;
    end else begin
      s = v[DW-1:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/polar_pursuit_p_controller_top.sv =====
// Register order: pre-rotation, micro-rotations, gain, range, products, output.
// Throughput: one transaction per cycle while results are accepted; each stage holds one item, so a
// stalled result only stops the stages behind it that are full.
// Latency follows the CORDIC micro-rotation chain, one register per rotation.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// configuration registers with 1.0, 1.5 and 4.0.
// ----------------------------------------------------------------------------
// polar_pursuit_p_controller_top
// Vectoring CORDIC turns a target offset into range and bearing, then two
// proportional terms give saturated linear and angular drive commands.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_pursuit_p_controller_top
  import pppc_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] dx_offset, [31:16] dy_offset
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [15:0] linear_drive, [31:16] angular_drive,
                                       // [47:32] range_value, [63:48] bearing_value
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int NCORD = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int NS    = NCORD + 5;
  localparam int S_M1  = NCORD + 1;
  localparam int S_M2  = NCORD + 2;
  localparam int S_M3  = NCORD + 3;
  localparam int S_OUT = NCORD + 4;

  // configuration registers
  logic [14:0] td_r;
  logic [11:0] lg_r;
  logic [11:0] ag_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_r <= TARGET_DIST_RST;
      lg_r <= LINEAR_GAIN_RST;
      ag_r <= ANGULAR_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET_DIST:  td_r <= cfg_data[14:0];
        REG_LINEAR_GAIN:  lg_r <= cfg_data[11:0];
        REG_ANGULAR_GAIN: ag_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage ready chain
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] rdy;

  assign rdy[NS-1] = ~v_r[NS-1] | out_tready;
  assign v_nxt[0]  = rdy[0] ? in_tvalid : v_r[0];

  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k]     = ~v_r[k] | rdy[k+1];
    assign v_nxt[k+1] = rdy[k+1] ? v_r[k] : v_r[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = rdy[0];

  // cordic datapath, index 0 is the pre-rotation stage
  cord_t      x_r   [0:NCORD];
  cord_t      y_r   [0:NCORD];
  cord_t      z_r   [0:NCORD];
  logic       org_r [0:NCORD];

  // pre-rotation: scale to Q12.22 and fold the left half plane
  logic [DW-1:0] dx;
  logic [DW-1:0] dy;
  cord_t         xi;
  cord_t         yi;
  cord_t         x0_nxt;
  cord_t         y0_nxt;
  cord_t         z0_nxt;

  assign dx = in_tdata[15:0];
  assign dy = in_tdata[31:16];
  assign xi = {{(CW-DW-XFRAC){dx[DW-1]}}, dx, {XFRAC{1'b0}}};
  assign yi = {{(CW-DW-XFRAC){dy[DW-1]}}, dy, {XFRAC{1'b0}}};

  always_comb begin
    x0_nxt = xi;
    y0_nxt = yi;
    z0_nxt = '0;
    if (dx[DW-1]) begin
      if (!dy[DW-1]) begin
        x0_nxt = yi;
        y0_nxt = -xi;
        z0_nxt = HALF_PI_Q30;
      end else begin
        x0_nxt = -yi;
        y0_nxt = xi;
        z0_nxt = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_r[0]   <= x0_nxt;
      y_r[0]   <= y0_nxt;
      z_r[0]   <= z0_nxt;
      org_r[0] <= (dx == '0) && (dy == '0);
    end
  end

  // micro-rotation stages, one per register
  for (genvar k = 1; k <= NCORD; k++) begin : g_rot
    cord_t xs;
    cord_t ys;
    cord_t x_nxt;
    cord_t y_nxt;
    cord_t z_nxt;

    assign xs = x_r[k-1] >>> (k - 1);
    assign ys = y_r[k-1] >>> (k - 1);

    always_comb begin
      if (!y_r[k-1][CW-1]) begin
        x_nxt = x_r[k-1] + ys;
        y_nxt = y_r[k-1] - xs;
        z_nxt = z_r[k-1] + atan_q30(5'(k - 1));
      end else begin
        x_nxt = x_r[k-1] - ys;
        y_nxt = y_r[k-1] + xs;
        z_nxt = z_r[k-1] - atan_q30(5'(k - 1));
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        x_r[k]   <= x_nxt;
        y_r[k]   <= y_nxt;
        z_r[k]   <= z_nxt;
        org_r[k] <= org_r[k-1];
      end
    end
  end

  // gain compensation product and bearing rounding
  cord_t                 xc;
  cord_t                 zsh;
  logic [62:0]           m1_prod_nxt;
  logic signed [DW-1:0]  m1_brg_nxt;
  logic [62:0]           m1_prod_r;
  logic signed [DW-1:0]  m1_brg_r;
  logic                  m1_org_r;

  assign xc          = x_r[NCORD][CW-1] ? '0 : x_r[NCORD];
  assign m1_prod_nxt = 63'(xc[32:0]) * 63'(GAIN_K_Q30);
  assign zsh         = (z_r[NCORD] + 34'sd65536) >>> 17;

  always_comb begin
    if (org_r[NCORD]) begin
      m1_brg_nxt = '0;
    end else if (zsh > cord_t'(BEARING_LIMIT)) begin
      m1_brg_nxt = BEARING_LIMIT;
    end else if (zsh < -cord_t'(BEARING_LIMIT)) begin
      m1_brg_nxt = -BEARING_LIMIT;
    end else begin
      m1_brg_nxt = zsh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_M1]) begin
      m1_prod_r <= m1_prod_nxt;
      m1_brg_r  <= m1_brg_nxt;
      m1_org_r  <= org_r[NCORD];
    end
  end

  // range rounding, cap and distance error
  logic [63:0]           rsum;
  logic [19:0]           rq;
  logic [DW-1:0]         m2_rng_nxt;
  logic signed [16:0]    m2_err_nxt;
  logic [DW-1:0]         m2_rng_r;
  logic signed [16:0]    m2_err_r;
  logic signed [DW-1:0]  m2_brg_r;

  assign rsum = 64'(m1_prod_r) + (64'd1 << 43);
  assign rq   = rsum[63:44];

  always_comb begin
    if (m1_org_r) begin
      m2_rng_nxt = '0;
    end else if (|rq[19:16]) begin
      m2_rng_nxt = 16'hFFFF;
    end else begin
      m2_rng_nxt = rq[15:0];
    end
  end

  assign m2_err_nxt = $signed({1'b0, m2_rng_nxt}) - $signed({2'b00, td_r});

  always_ff @(posedge clk) begin
    if (rdy[S_M2]) begin
      m2_rng_r <= m2_rng_nxt;
      m2_err_r <= m2_err_nxt;
      m2_brg_r <= m1_brg_r;
    end
  end

  // proportional products
  logic signed [29:0]    m3_lin_r;
  logic signed [28:0]    m3_ang_r;
  logic [DW-1:0]         m3_rng_r;
  logic signed [DW-1:0]  m3_brg_r;

  always_ff @(posedge clk) begin
    if (rdy[S_M3]) begin
      m3_lin_r <= 30'(m2_err_r) * 30'($signed({1'b0, lg_r}));
      m3_ang_r <= 29'(m2_brg_r) * 29'($signed({1'b0, ag_r}));
      m3_rng_r <= m2_rng_r;
      m3_brg_r <= m2_brg_r;
    end
  end

  // rounding shift and saturation into the output register
  logic signed [29:0]    lin_sh;
  logic signed [28:0]    ang_sh;
  logic signed [DW-1:0]  out_lin_r;
  logic signed [DW-1:0]  out_ang_r;
  logic [DW-1:0]         out_rng_r;
  logic signed [DW-1:0]  out_brg_r;

  assign lin_sh = (m3_lin_r + 30'sd128) >>> 8;
  assign ang_sh = (m3_ang_r + 29'sd4096) >>> 13;

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      out_lin_r <= sat16(32'(lin_sh));
      out_ang_r <= sat16(32'(ang_sh));
      out_rng_r <= m3_rng_r;
      out_brg_r <= m3_brg_r;
    end
  end

  assign out_tvalid = v_r[S_OUT];
  assign out_tdata  = {out_brg_r, out_rng_r, out_ang_r, out_lin_r};

endmodule

`default_nettype wire

// ===== rtl/core/pppc_checker.sv =====
// ----------------------------------------------------------------------------
// pppc_checker
// Port-level checks for the polar pursuit proportional controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pppc_checker
  import pppc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);

  logic signed [DW-1:0] brg;
  logic signed [DW-1:0] ang;

  assign brg = out_tdata[63:48];
  assign ang = out_tdata[31:16];

  // a pending result transaction holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // bearing stays within plus or minus pi
  a_brg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (brg <= BEARING_LIMIT) && (brg >= -BEARING_LIMIT))
    else $error("bearing out of range");

  // zero bearing gives no turn command
  a_ang_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (brg == '0) |-> (ang == '0))
    else $error("turn command without bearing");

endmodule

bind polar_pursuit_p_controller_top pppc_checker u_pppc_checker (.*);

`default_nettype wire
